FILE: rtl/egcd_pkg.sv
// egcd_pkg: shared constants and sequencer state type for the extended GCD block.
// No dependencies; imported by egcd_divstep and extended_gcd_top.
package egcd_pkg;

   localparam int EGCD_WIDTH = 32;
   localparam int STEP_W     = 6;
   localparam logic [STEP_W-1:0] STEP_MAX = 6'd63;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PREP  = 6'b000010,
      S_START = 6'b000100,
      S_WAIT  = 6'b001000,
      S_FIN   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

endpackage

FILE: rtl/egcd_divstep.sv
// egcd_divstep: one Euclid step - restoring divider, one quotient bit a cycle,
// with two Horner accumulators forming quotient*coef mod 2^WIDTH alongside.
// Depends on egcd_pkg.
module egcd_divstep import egcd_pkg::*; #(
   parameter int WIDTH = EGCD_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   input  logic [WIDTH-1:0] mul_x,
   input  logic [WIDTH-1:0] mul_y,
   output logic             done,
   output logic [WIDTH-1:0] remainder,
   output logic [WIDTH-1:0] prod_x,
   output logic [WIDTH-1:0] prod_y
);

   localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH-1:0] mx_ff, mx_in;
   logic [WIDTH-1:0] my_ff, my_in;
   logic [WIDTH-1:0] accx_ff, accx_in;
   logic [WIDTH-1:0] accy_ff, accy_in;

   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   trial;
   logic             qbit;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign qbit    = ~trial[WIDTH];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      accx_in = accx_ff;
      accy_in = accy_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         mx_in   = mul_x;
         my_in   = mul_y;
         accx_in = '0;
         accy_in = '0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[WIDTH-2:0], qbit};
         rem_in  = qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
         accx_in = {accx_ff[WIDTH-2:0], 1'b0} + (qbit ? mx_ff : '0);
         accy_in = {accy_ff[WIDTH-2:0], 1'b0} + (qbit ? my_ff : '0);
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
   assign prod_x    = accx_ff;
   assign prod_y    = accy_ff;

endmodule

FILE: rtl/extended_gcd_top.sv
// Extended GCD of two signed WIDTH-bit operands: gives gcd(|a|,|b|), Bezout
// coefficients (wrapping mod 2^WIDTH) and the count of nonzero-remainder
// Euclid steps, saturating at 63. One item is handled at a time; req_tready
// is high only when the block is idle. After the input beat the operands
// are registered, then S_PREP takes magnitudes and orders them; a zero
// operand goes straight to S_FIN. Each Euclid step passes through S_START
// and S_WAIT on the shared restoring divider, then S_FIN raises rsp_tvalid.
// The next input beat can be taken only once the result beat has been
// accepted and the block is back in S_IDLE. At WIDTH 32 the worst-case step
// count is 43, for neighbouring Fibonacci operands. The result beat
// is held in an output register until rsp_tready.
// Depends on egcd_pkg and egcd_divstep.
module extended_gcd_top import egcd_pkg::*; #(
   parameter int WIDTH = EGCD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   // first_value, second_value
   input  logic [((2*WIDTH+7)/8)*8-1:0]        req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // divisor, coef_first, coef_second, step_count
   output logic [((3*WIDTH+STEP_W+7)/8)*8-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);

   localparam int RSP_W = ((3*WIDTH+STEP_W+7)/8)*8;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic             neg_a_ff, neg_a_in;
   logic             neg_b_ff, neg_b_in;
   logic             swap_ff, swap_in;
   logic [WIDTH-1:0] big_ff, big_in;
   logic [WIDTH-1:0] small_ff, small_in;
   logic [WIDTH-1:0] px_ff, px_in;
   logic [WIDTH-1:0] py_ff, py_in;
   logic [WIDTH-1:0] cx_ff, cx_in;
   logic [WIDTH-1:0] cy_ff, cy_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             req_beat;
   logic [WIDTH-1:0] mag_a, mag_b;
   logic [WIDTH-1:0] fin_x, fin_y, fin_g;
   logic             div_start, div_done;
   logic [WIDTH-1:0] div_rem, div_px, div_py;

   assign req_beat   = req_tvalid & req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign div_start  = (state_ff == S_START);

   assign mag_a = a_ff[WIDTH-1] ? (WIDTH'(0) - a_ff) : a_ff;
   assign mag_b = b_ff[WIDTH-1] ? (WIDTH'(0) - b_ff) : b_ff;

   egcd_divstep #(
      .WIDTH (WIDTH)
   ) u_divstep (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (big_ff),
      .divisor   (small_ff),
      .mul_x     (cx_ff),
      .mul_y     (cy_ff),
      .done      (div_done),
      .remainder (div_rem),
      .prod_x    (div_px),
      .prod_y    (div_py)
   );

   always_comb begin
      fin_x = swap_ff ? cy_ff : cx_ff;
      fin_y = swap_ff ? cx_ff : cy_ff;
      if (neg_a_ff) begin
         fin_x = WIDTH'(0) - fin_x;
      end
      if (neg_b_ff) begin
         fin_y = WIDTH'(0) - fin_y;
      end
      fin_g = (small_ff == '0) ? big_ff : small_ff;
   end

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      neg_a_in     = neg_a_ff;
      neg_b_in     = neg_b_ff;
      swap_in      = swap_ff;
      big_in       = big_ff;
      small_in     = small_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      steps_in     = steps_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               a_in     = req_tdata[WIDTH-1:0];
               b_in     = req_tdata[2*WIDTH-1:WIDTH];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            neg_a_in = a_ff[WIDTH-1];
            neg_b_in = b_ff[WIDTH-1];
            steps_in = '0;
            if (mag_a < mag_b) begin
               swap_in  = 1'b1;
               big_in   = mag_b;
               small_in = mag_a;
            end else begin
               swap_in  = 1'b0;
               big_in   = mag_a;
               small_in = mag_b;
            end
            if (small_in == '0) begin
               // one or both operands zero
               cx_in    = WIDTH'(big_in != '0);
               cy_in    = '0;
               state_in = S_FIN;
            end else begin
               px_in    = WIDTH'(1);
               py_in    = '0;
               cx_in    = '0;
               cy_in    = WIDTH'(1);
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  state_in = S_FIN;
               end else begin
                  px_in    = cx_ff;
                  py_in    = cy_ff;
                  cx_in    = px_ff - div_px;
                  cy_in    = py_ff - div_py;
                  big_in   = small_ff;
                  small_in = div_rem;
                  if (steps_ff != STEP_MAX) begin
                     steps_in = steps_ff + 1'b1;
                  end
                  state_in = S_START;
               end
            end
         end
         S_FIN: begin
            rsp_data_in = '0;
            rsp_data_in[WIDTH-1:0]         = fin_g;
            rsp_data_in[2*WIDTH-1:WIDTH]   = fin_x;
            rsp_data_in[3*WIDTH-1:2*WIDTH] = fin_y;
            rsp_data_in[3*WIDTH+STEP_W-1:3*WIDTH] = steps_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      neg_a_ff    <= neg_a_in;
      neg_b_ff    <= neg_b_in;
      swap_ff     <= swap_in;
      big_ff      <= big_in;
      small_ff    <= small_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // never take a new beat while a result is still on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_tready)
      else $error("input accepted while result pending");

   // the divider only ever finishes while the sequencer is waiting on it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_WAIT))
      else $error("divider done outside wait state");

   // a Euclid step is never started with a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (small_ff != '0))
      else $error("divide step started with zero divisor");

   // result register is only released by a completed output beat
   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_tready))
      else $error("result dropped without handshake");

endmodule
